@@ sv/dda_pkg.sv @@
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and constants for the DDA line point generator.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int POS_BITS   = COORD_BITS + FRAC_BITS;
  localparam int INC_BITS   = FRAC_BITS + 2;
  localparam int QUO_BITS   = FRAC_BITS + 1;
  localparam int CNT_BITS   = $clog2(FRAC_BITS);

  typedef enum logic [0:0] {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    ST_OK      = 1'b0,
    ST_NO_LINE = 1'b1
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE   = 1'b0,
    S_DIVIDE = 1'b1
  } state_t;

  typedef struct packed {
    op_t                   operation;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  last_point;
    status_t               status;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic adv;
    logic div_step;
    logic div_last;
  } dda_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic steps_zero;
  } dda_sts_t;

endpackage

@@ sv/dda_ctrl.sv @@
// ----------------------------------------------------------------------------
// dda_ctrl
// Controller: input handshake, output valid, and the slope division sequence.
// ----------------------------------------------------------------------------
module dda_ctrl
  import dda_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  op_t      in_op,
  input  logic     out_stall,
  input  dda_sts_t sts,
  output dda_cmd_t cmd,
  output logic     in_stall,
  output logic     out_valid
);

  state_t              state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                accept;
  logic                cnt_last;

  assign cnt_last  = (cnt_r == CNT_BITS'(FRAC_BITS - 1));
  assign out_valid = out_valid_r;

  // next state and iteration counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (cmd.start && !sts.steps_zero) begin
          state_nxt = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // handshake and datapath commands
  always_comb begin
    in_stall     = (state_r != S_IDLE) || (out_valid_r && out_stall);
    accept       = in_valid && !in_stall;
    cmd.start    = accept && (in_op == OP_START);
    cmd.adv      = accept && (in_op == OP_ADVANCE);
    cmd.div_step = (state_r == S_DIVIDE);
    cmd.div_last = (state_r == S_DIVIDE) && cnt_last;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ sv/dda_dp.sv @@
// ----------------------------------------------------------------------------
// dda_dp
// Datapath: position and increment registers, bit-serial slope divider,
// point rounding and the result register.
// ----------------------------------------------------------------------------
module dda_dp
  import dda_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  in_t      in_data,
  input  dda_cmd_t cmd,
  output dda_sts_t sts,
  output out_t     out_data
);

  localparam logic [POS_BITS-1:0] HALF_LSB = POS_BITS'(1) << (FRAC_BITS - 1);

  logic [POS_BITS-1:0]   cur_x_r, cur_y_r;
  logic [INC_BITS-1:0]   inc_x_r, inc_y_r;
  logic [COORD_BITS-1:0] steps_left_r;
  logic                  active_r;
  logic [COORD_BITS-1:0] div_steps_r;
  logic [COORD_BITS-1:0] rem_x_r, rem_y_r;
  logic [QUO_BITS-1:0]   quo_x_r, quo_y_r;
  logic                  neg_x_r, neg_y_r;
  out_t                  out_r;

  // start item: deltas and step count
  logic                  neg_x, neg_y;
  logic [COORD_BITS-1:0] adx, ady, steps;

  assign neg_x = (in_data.end_x < in_data.start_x);
  assign neg_y = (in_data.end_y < in_data.start_y);
  assign adx   = neg_x ? (in_data.start_x - in_data.end_x) : (in_data.end_x - in_data.start_x);
  assign ady   = neg_y ? (in_data.start_y - in_data.end_y) : (in_data.end_y - in_data.start_y);
  assign steps = (adx > ady) ? adx : ady;
  assign sts.steps_zero = (steps == '0);

  // one quotient bit per cycle for each axis
  logic [COORD_BITS:0]   rx2, ry2;
  logic                  gex, gey;
  logic [COORD_BITS-1:0] rem_x_nxt, rem_y_nxt;
  logic [QUO_BITS-1:0]   quo_x_nxt, quo_y_nxt;

  assign rx2       = {rem_x_r, 1'b0};
  assign ry2       = {rem_y_r, 1'b0};
  assign gex       = (rx2 >= {1'b0, div_steps_r});
  assign gey       = (ry2 >= {1'b0, div_steps_r});
  assign rem_x_nxt = gex ? COORD_BITS'(rx2 - {1'b0, div_steps_r}) : rx2[COORD_BITS-1:0];
  assign rem_y_nxt = gey ? COORD_BITS'(ry2 - {1'b0, div_steps_r}) : ry2[COORD_BITS-1:0];
  assign quo_x_nxt = {quo_x_r[QUO_BITS-2:0], gex};
  assign quo_y_nxt = {quo_y_r[QUO_BITS-2:0], gey};

  // advance: step position and round half up
  logic [POS_BITS-1:0]   sum_x, sum_y, rnd_x, rnd_y;
  logic                  adv_ok, adv_last;

  assign sum_x    = cur_x_r + {{(POS_BITS-INC_BITS){inc_x_r[INC_BITS-1]}}, inc_x_r};
  assign sum_y    = cur_y_r + {{(POS_BITS-INC_BITS){inc_y_r[INC_BITS-1]}}, inc_y_r};
  assign rnd_x    = sum_x + HALF_LSB;
  assign rnd_y    = sum_y + HALF_LSB;
  assign adv_ok   = active_r && (steps_left_r != '0);
  assign adv_last = (steps_left_r == COORD_BITS'(1));

  // line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      inc_x_r      <= '0;
      inc_y_r      <= '0;
      steps_left_r <= '0;
      active_r     <= 1'b0;
    end else begin
      if (cmd.start) begin
        cur_x_r      <= {in_data.start_x, {FRAC_BITS{1'b0}}};
        cur_y_r      <= {in_data.start_y, {FRAC_BITS{1'b0}}};
        inc_x_r      <= '0;
        inc_y_r      <= '0;
        steps_left_r <= steps;
        active_r     <= !sts.steps_zero;
      end else if (cmd.adv) begin
        if (adv_ok) begin
          cur_x_r      <= sum_x;
          cur_y_r      <= sum_y;
          steps_left_r <= steps_left_r - 1'b1;
          active_r     <= !adv_last;
        end else begin
          active_r     <= 1'b0;
        end
      end else if (cmd.div_last) begin
        inc_x_r <= neg_x_r ? INC_BITS'(-{1'b0, quo_x_nxt}) : INC_BITS'({1'b0, quo_x_nxt});
        inc_y_r <= neg_y_r ? INC_BITS'(-{1'b0, quo_y_nxt}) : INC_BITS'({1'b0, quo_y_nxt});
      end
    end
  end

  // divider working registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      div_steps_r <= steps;
      neg_x_r     <= neg_x;
      neg_y_r     <= neg_y;
      // integer part is one only for the major axis
      rem_x_r     <= (adx == steps) ? '0 : adx;
      rem_y_r     <= (ady == steps) ? '0 : ady;
      quo_x_r     <= QUO_BITS'(adx == steps);
      quo_y_r     <= QUO_BITS'(ady == steps);
    end else if (cmd.div_step) begin
      rem_x_r <= rem_x_nxt;
      rem_y_r <= rem_y_nxt;
      quo_x_r <= quo_x_nxt;
      quo_y_r <= quo_y_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      out_r.point_x    <= in_data.start_x;
      out_r.point_y    <= in_data.start_y;
      out_r.last_point <= sts.steps_zero;
      out_r.status     <= ST_OK;
    end else if (cmd.adv) begin
      if (adv_ok) begin
        out_r.point_x    <= rnd_x[POS_BITS-1:FRAC_BITS];
        out_r.point_y    <= rnd_y[POS_BITS-1:FRAC_BITS];
        out_r.last_point <= adv_last;
        out_r.status     <= ST_OK;
      end else begin
        out_r.point_x    <= '0;
        out_r.point_y    <= '0;
        out_r.last_point <= 1'b0;
        out_r.status     <= ST_NO_LINE;
      end
    end
  end

  assign out_data = out_r;

endmodule

@@ sv/dda_line_point_generator.sv @@
// ----------------------------------------------------------------------------
// dda_line_point_generator
// DDA line rasterizer: a start transaction latches a line and returns its
// start point, each advance transaction returns the next rounded point.
// ----------------------------------------------------------------------------
// An advance transaction is taken one per clock while the result side keeps
// up; its point is ready in the output register on the next cycle. A start
// transaction returns its start point on the next cycle, then the block holds
// in_stall while the datapath divider forms both slopes, one quotient bit per
// cycle. A start with equal endpoints returns a single point flagged last and
// needs no division. An advance with no active line returns status 1 and zero
// fields.
module dda_line_point_generator
  import dda_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  dda_cmd_t cmd;
  dda_sts_t sts;

  // sequencing and handshake
  dda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // arithmetic and line state
  dda_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

@@ sv/dda_chk.sv @@
// ----------------------------------------------------------------------------
// dda_chk
// Port-level checks for the DDA line point generator, bound to the top level.
// ----------------------------------------------------------------------------
module dda_chk
  import dda_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an error result carries no point
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_NO_LINE |->
      out_data.point_x == '0 && out_data.point_y == '0 && !out_data.last_point)
    else $error("error result with nonzero fields");

  // a start returns its start point next cycle
  a_start_pt: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.operation == OP_START |=>
      out_valid && out_data.point_x == $past(in_data.start_x) &&
      out_data.point_y == $past(in_data.start_y) && out_data.status == ST_OK)
    else $error("start point mismatch");

  // a real line start keeps input stalled while slopes divide
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.operation == OP_START &&
      (in_data.start_x != in_data.end_x || in_data.start_y != in_data.end_y)
      |=> in_stall && !out_data.last_point)
    else $error("input taken during slope division");

endmodule

bind dda_line_point_generator dda_chk u_dda_chk (.*);
